// File: rtl/eafr_pkg.sv
// eafr_pkg: shared types and constants for the escaped api frame receiver
// no dependencies; imported by every module of the block

package eafr_pkg;

    // framing codes on the serial link
    localparam logic [7:0] START_CODE = 8'h7E;
    localparam logic [7:0] ESC_CODE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;

    // header bytes counted in the length field besides the payload
    localparam logic [15:0] HEADER_LEN = 16'd12;

    // checksum base
    localparam logic [7:0] SUM_BASE = 8'hFF;

    // configuration register map
    localparam int unsigned REG_FRAME_TYPE  = 0;
    localparam logic [7:0]  FRAME_TYPE_RESET = 8'h90;

    // result status codes
    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // frame descriptor passed from the parser to the emitter
    typedef struct packed {
        logic        status;
        logic [6:0]  count;
        logic [63:0] src_addr;
        logic [15:0] net_addr;
        logic [7:0]  options;
    } frame_desc_t;

endpackage

// File: rtl/eafr_fifo.sv
// eafr_fifo: two-entry queue of frame descriptors between parser and emitter
// depends on eafr_pkg for frame_desc_t

module eafr_fifo
    import eafr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_desc,
    input  logic        pop,
    output frame_desc_t pop_desc,
    output logic        full,
    output logic        empty
);

    frame_desc_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_desc = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // descriptor storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: rtl/eafr_parse.sv
// eafr_parse: byte-level deframer; strips escapes, parses the header,
// writes payload bytes to the store and queues one descriptor per checked frame
// depends on eafr_pkg

module eafr_parse
    import eafr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int IDX_W       = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       frame_type,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             queue_full,
    input  logic             store_busy,
    output logic             push,
    output frame_desc_t      push_desc,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output logic [7:0]       wr_data
);

    localparam logic [15:0] MAX_LEN = 16'(HEADER_LEN + 16'(MAX_PAYLOAD));

    typedef enum logic [9:0] {
        P_IDLE   = 10'b0000000001,
        P_LEN_HI = 10'b0000000010,
        P_LEN_LO = 10'b0000000100,
        P_TYPE   = 10'b0000001000,
        P_ADDR   = 10'b0000010000,
        P_NET_HI = 10'b0000100000,
        P_NET_LO = 10'b0001000000,
        P_OPT    = 10'b0010000000,
        P_DATA   = 10'b0100000000,
        P_SUM    = 10'b1000000000
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic        esc_reg;
    logic        esc_next;
    logic [2:0]  addr_cnt_reg;
    logic [2:0]  addr_cnt_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic [63:0] src_reg;
    logic [63:0] src_next;
    logic [15:0] net_reg;
    logic [15:0] net_next;
    logic [7:0]  opt_reg;
    logic [7:0]  opt_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [6:0]  recv_reg;
    logic [6:0]  recv_next;
    logic [6:0]  expect_reg;
    logic [6:0]  expect_next;
    logic        accept;
    logic [7:0]  data_byte;

    // hold input while the queue is full, and hold payload bytes while the store is still being read out
    assign in_stall = queue_full || ((phase_reg == P_DATA) && store_busy);
    assign accept   = in_valid && !in_stall;

    assign data_byte = esc_reg ? (rx_byte ^ ESC_XOR) : rx_byte;

    assign push_desc.status   = ((SUM_BASE - sum_reg) == data_byte) ? STATUS_GOOD : STATUS_BAD;
    assign push_desc.count    = expect_reg;
    assign push_desc.src_addr = src_reg;
    assign push_desc.net_addr = net_reg;
    assign push_desc.options  = opt_reg;

    assign wr_addr = recv_reg[IDX_W-1:0];
    assign wr_data = data_byte;

    // frame parser
    always_comb
    begin
        phase_next    = phase_reg;
        esc_next      = esc_reg;
        addr_cnt_next = addr_cnt_reg;
        length_next   = length_reg;
        src_next      = src_reg;
        net_next      = net_reg;
        opt_next      = opt_reg;
        sum_next      = sum_reg;
        recv_next     = recv_reg;
        expect_next   = expect_reg;
        push          = 1'b0;
        wr_en         = 1'b0;
        if (accept)
        begin
            if (rx_byte == START_CODE)
            begin
                phase_next = P_LEN_HI;
                esc_next   = 1'b0;
            end
            else if (rx_byte == ESC_CODE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                unique case (phase_reg)
                    P_IDLE:
                    begin
                        phase_next = P_IDLE;
                    end
                    P_LEN_HI:
                    begin
                        length_next = {data_byte, 8'h00};
                        phase_next  = P_LEN_LO;
                    end
                    P_LEN_LO:
                    begin
                        length_next = {length_reg[15:8], data_byte};
                        phase_next  = P_TYPE;
                    end
                    P_TYPE:
                    begin
                        sum_next      = data_byte;
                        addr_cnt_next = 3'd0;
                        phase_next    = (data_byte == frame_type) ? P_ADDR : P_IDLE;
                    end
                    P_ADDR:
                    begin
                        src_next      = {src_reg[55:0], data_byte};
                        sum_next      = sum_reg + data_byte;
                        addr_cnt_next = addr_cnt_reg + 3'd1;
                        if (addr_cnt_reg == 3'd7)
                        begin
                            phase_next = P_NET_HI;
                        end
                    end
                    P_NET_HI:
                    begin
                        net_next   = {data_byte, 8'h00};
                        sum_next   = sum_reg + data_byte;
                        phase_next = P_NET_LO;
                    end
                    P_NET_LO:
                    begin
                        net_next   = {net_reg[15:8], data_byte};
                        sum_next   = sum_reg + data_byte;
                        phase_next = P_OPT;
                    end
                    P_OPT:
                    begin
                        opt_next  = data_byte;
                        sum_next  = sum_reg + data_byte;
                        recv_next = 7'd0;
                        if ((length_reg <= HEADER_LEN) || (length_reg > MAX_LEN))
                        begin
                            phase_next = P_IDLE;
                        end
                        else
                        begin
                            expect_next = 7'(length_reg - HEADER_LEN);
                            phase_next  = P_DATA;
                        end
                    end
                    P_DATA:
                    begin
                        wr_en     = 1'b1;
                        recv_next = recv_reg + 7'd1;
                        sum_next  = sum_reg + data_byte;
                        if ((recv_reg + 7'd1) >= expect_reg)
                        begin
                            phase_next = P_SUM;
                        end
                    end
                    P_SUM:
                    begin
                        push       = 1'b1;
                        phase_next = P_IDLE;
                    end
                    default:
                    begin
                        phase_next = P_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= P_IDLE;
            esc_reg      <= 1'b0;
            addr_cnt_reg <= 3'd0;
            length_reg   <= 16'd0;
            src_reg      <= 64'd0;
            net_reg      <= 16'd0;
            opt_reg      <= 8'd0;
            sum_reg      <= 8'd0;
            recv_reg     <= 7'd0;
            expect_reg   <= 7'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            esc_reg      <= esc_next;
            addr_cnt_reg <= addr_cnt_next;
            length_reg   <= length_next;
            src_reg      <= src_next;
            net_reg      <= net_next;
            opt_reg      <= opt_next;
            sum_reg      <= sum_next;
            recv_reg     <= recv_next;
            expect_reg   <= expect_next;
        end
    end

endmodule

// File: rtl/eafr_emit.sv
// eafr_emit: payload store and readout sequencer; turns one descriptor into
// a run of payload results or a single error result
// depends on eafr_pkg

module eafr_emit
    import eafr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int IDX_W       = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             queue_empty,
    input  frame_desc_t      pop_desc,
    output logic             pop,
    output logic             active,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       payload_byte,
    output logic             is_last,
    output logic             frame_status,
    output logic [63:0]      source_address,
    output logic [15:0]      source_network_address,
    output logic [7:0]       receive_options,
    output logic [6:0]       payload_length
);

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_READ = 3'b010,
        E_SEND = 3'b100
    } emit_state_t;

    logic [7:0]  store_mem [MAX_PAYLOAD];
    logic [7:0]  rd_data_reg;
    emit_state_t state_reg;
    emit_state_t state_next;
    frame_desc_t desc_reg;
    frame_desc_t desc_next;
    logic [6:0]  idx_reg;
    logic [6:0]  idx_next;
    logic        last;

    assign active = (state_reg != E_IDLE);
    assign pop    = (state_reg == E_IDLE) && !queue_empty;
    assign last   = (desc_reg.status == STATUS_BAD) || (idx_reg == (desc_reg.count - 7'd1));

    // result fields straight from registers
    assign out_valid              = (state_reg == E_SEND);
    assign payload_byte           = (desc_reg.status == STATUS_BAD) ? 8'h00 : rd_data_reg;
    assign is_last                = last;
    assign frame_status           = desc_reg.status;
    assign source_address         = desc_reg.src_addr;
    assign source_network_address = desc_reg.net_addr;
    assign receive_options        = desc_reg.options;
    assign payload_length         = desc_reg.count;

    // payload store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[idx_reg[IDX_W-1:0]];
    end

    // readout sequencer
    always_comb
    begin
        state_next = state_reg;
        desc_next  = desc_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (!queue_empty)
                begin
                    desc_next  = pop_desc;
                    idx_next   = 7'd0;
                    state_next = (pop_desc.status == STATUS_BAD) ? E_SEND : E_READ;
                end
            end
            E_READ:
            begin
                state_next = E_SEND;
            end
            E_SEND:
            begin
                if (!out_stall)
                begin
                    if (last)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 7'd1;
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            idx_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

// File: rtl/escaped_api_frame_receiver.sv
// escaped_api_frame_receiver: top level; config register, parser, queue, emitter
// depends on eafr_pkg, eafr_parse, eafr_fifo, eafr_emit
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | rx_byte
//  output   | out_valid / out_stall| payload_byte, is_last, frame_status,
//           |                      | source_address, source_network_address,
//           |                      | receive_options, payload_length
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// the parser takes one byte per cycle while in_stall is low
// a good frame reads out each payload byte by a store read, then a send that holds while out_stall is high
// an error result is presented in the cycle after its descriptor is dequeued
// payload bytes of the next frame stall while an earlier readout is pending
// reset clears parser, queue and sequencer; the payload store is not cleared

module escaped_api_frame_receiver
    import eafr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        is_last,
    output logic        frame_status,
    output logic [63:0] source_address,
    output logic [15:0] source_network_address,
    output logic [7:0]  receive_options,
    output logic [6:0]  payload_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]       frame_type_reg;
    logic [7:0]       frame_type_next;
    logic             reg_sel;
    logic             push;
    logic             pop;
    frame_desc_t      push_desc;
    frame_desc_t      pop_desc;
    logic             queue_full;
    logic             queue_empty;
    logic             emit_active;
    logic             store_busy;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'(REG_FRAME_TYPE));
    assign prdata  = reg_sel ? {24'd0, frame_type_reg} : 32'd0;

    always_comb
    begin
        frame_type_next = frame_type_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            frame_type_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_type_reg <= FRAME_TYPE_RESET;
        end
        else
        begin
            frame_type_reg <= frame_type_next;
        end
    end

    // store is busy until every queued frame has been read out
    assign store_busy = !queue_empty || emit_active;

    eafr_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_type (frame_type_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .store_busy (store_busy),
        .push       (push),
        .push_desc  (push_desc),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    eafr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    eafr_emit #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W)
    ) u_emit (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .wr_en                  (wr_en),
        .wr_addr                (wr_addr),
        .wr_data                (wr_data),
        .queue_empty            (queue_empty),
        .pop_desc               (pop_desc),
        .pop                    (pop),
        .active                 (emit_active),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .payload_byte           (payload_byte),
        .is_last                (is_last),
        .frame_status           (frame_status),
        .source_address         (source_address),
        .source_network_address (source_network_address),
        .receive_options        (receive_options),
        .payload_length         (payload_length)
    );

endmodule
